FILE: design/lsh_bt_pkg.sv
package lsh_bt_pkg;

   localparam int MAX_TABLES   = 8;
   localparam int INDEX_BITS   = 10;
   localparam int BUCKET_SLOTS = 16;
   localparam int ID_BITS      = 31;

   localparam int CFG_BITS     = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CMD_BITS     = 2;
   localparam int HASH_BITS    = 10;
   localparam int TNUM_BITS    = 3;
   localparam int HCNT_BITS    = 4;

   localparam int TAB_BITS     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int SLOT_BITS    = $clog2(BUCKET_SLOTS);
   localparam int FILL_BITS    = SLOT_BITS + 1;
   localparam int FILL_MAX     = 2 * BUCKET_SLOTS - 1;
   localparam int BUCKET_BITS  = TAB_BITS + INDEX_BITS;
   localparam int NUM_BUCKETS  = MAX_TABLES * (1 << INDEX_BITS);
   localparam int NUM_ENTRIES  = NUM_BUCKETS * BUCKET_SLOTS;
   localparam int ENTRY_BITS   = BUCKET_BITS + SLOT_BITS;
   localparam int ACT_BITS     = (TAB_BITS + 1 > CFG_BITS) ? TAB_BITS + 1 : CFG_BITS;

   localparam logic [CFG_BITS-1:0] HPT_RESET = CFG_BITS'(2);
   localparam logic [CFG_BITS-1:0] BPH_RESET = CFG_BITS'(5);
   localparam logic [CFG_BITS-1:0] TIU_RESET = CFG_BITS'(8);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HASHES_PER_TABLE = 2'd0,
      CSR_BITS_PER_HASH    = 2'd1,
      CSR_TABLES_IN_USE    = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_idx_type;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD      = 2'd0,
      CMD_RETRIEVE = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_STREAM,
      ST_EMPTY
   } state_type;

   function automatic logic [TNUM_BITS-1:0] tab_to_num(input logic [TAB_BITS-1:0] t);
      logic [TAB_BITS+TNUM_BITS-1:0] w;
      w = {{TNUM_BITS{1'b0}}, t};
      return w[TNUM_BITS-1:0];
   endfunction

endpackage

FILE: design/lsh_bucket_table.sv
// Per word: a hash word that does not complete an index is taken without a stall; a completing add
// does a fill read, then a write back; a completing retrieve does a fill read, then
// streams n results (n = stored ids, at most 16, or one empty marker) at one per cycle from
// the entry memory while results are not stalled, through the read data and result registers;
// the input stays stalled until the last read or the marker issues; result stalls stretch both.
// Reset and every clear command sweep the 8192-entry fill memory, one entry per cycle,
// with the input stalled. Entry memory contents stay undefined until written.
module lsh_bucket_table
   import lsh_bt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wr_data,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CMD_BITS-1:0]     req_cmd,
   input  logic [HASH_BITS-1:0]    req_hash_value,
   input  logic                    req_hash_valid,
   input  logic [ID_BITS-1:0]      req_item_id,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ID_BITS-1:0]      rsp_found_id,
   output logic [TNUM_BITS-1:0]    rsp_table_number,
   output logic                    rsp_bucket_empty,
   output logic                    rsp_last_of_bucket
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CFG_BITS-1:0] hpt_ff, bph_ff, tiu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hpt_ff <= HPT_RESET;
         bph_ff <= BPH_RESET;
         tiu_ff <= TIU_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_HASHES_PER_TABLE: hpt_ff <= csr_wr_data;
            CSR_BITS_PER_HASH:    bph_ff <= csr_wr_data;
            CSR_TABLES_IN_USE:    tiu_ff <= csr_wr_data;
            CSR_UNUSED:           ;
            default:              ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   state_type                state_ff, state_in;
   logic [BUCKET_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [HCNT_BITS-1:0]     hash_cnt_ff, hash_cnt_in;
   logic [TAB_BITS-1:0]      tab_ff, tab_in;
   logic [INDEX_BITS-1:0]    acc_ff, acc_in;
   logic [FILL_BITS-1:0]     slot_ff, slot_in;     // reads issued so far
   logic [FILL_BITS-1:0]     count_ff, count_in;   // reads to issue for this bucket
   logic                     dv_ff, dv_in;         // entry read data holds a word
   logic                     dv_last_ff, dv_last_in;
   logic [TAB_BITS-1:0]      dv_tab_ff, dv_tab_in; // table of the word in read data
   logic                     rsp_valid_ff, rsp_valid_in;

   // Payload registers for the bucket in flight
   logic [BUCKET_BITS-1:0]   bucket_ff, bucket_in;
   logic                     is_add_ff, is_add_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [TAB_BITS-1:0]      btab_ff, btab_in;

   // Result register
   logic [ID_BITS-1:0]       rsp_id_ff, rsp_id_in;
   logic [TNUM_BITS-1:0]     rsp_tab_ff, rsp_tab_in;
   logic                     rsp_empty_ff, rsp_empty_in;
   logic                     rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------------
   // Memories: fill counts and id rings, both with registered reads
   // ------------------------------------------------------------------
   logic [FILL_BITS-1:0]     fill_mem [NUM_BUCKETS];
   logic [FILL_BITS-1:0]     fill_rd_ff;
   logic                     fill_re, fill_we;
   logic [BUCKET_BITS-1:0]   fill_ra, fill_wa;
   logic [FILL_BITS-1:0]     fill_wd;

   logic [ID_BITS-1:0]       entry_mem [NUM_ENTRIES];
   logic [ID_BITS-1:0]       entry_rd_ff;
   logic                     entry_re, entry_we;
   logic [ENTRY_BITS-1:0]    entry_ra, entry_wa;

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
      if (fill_re) begin
         fill_rd_ff <= fill_mem[fill_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_wa] <= id_ff;
      end
      if (entry_re) begin
         entry_rd_ff <= entry_mem[entry_ra];
      end
   end

   // ------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------
   logic                     req_take;
   logic [INDEX_BITS-1:0]    acc_shift, acc_next;
   logic [HCNT_BITS-1:0]     hash_cnt_next, hash_need;
   logic                     index_done;
   logic [ACT_BITS-1:0]      tab_active, tab_plus;
   logic [FILL_BITS-1:0]     slot_plus;
   logic                     rsp_free, dv_move, empty_load;

   // Shift in the new hash; bits pushed past the index width drop out.
   assign acc_shift     = acc_ff << bph_ff;
   assign acc_next      = acc_shift + (req_hash_valid ? INDEX_BITS'(req_hash_value)
                                                      : INDEX_BITS'(0));
   assign hash_cnt_next = hash_cnt_ff + HCNT_BITS'(1);
   assign hash_need     = (hpt_ff == '0) ? HCNT_BITS'(1) : HCNT_BITS'(hpt_ff);
   assign index_done    = (hash_cnt_next >= hash_need);

   // Clamp tables in use to 1..MAX_TABLES.
   always_comb begin
      if (tiu_ff == '0) begin
         tab_active = ACT_BITS'(1);
      end else if (ACT_BITS'(tiu_ff) > ACT_BITS'(MAX_TABLES)) begin
         tab_active = ACT_BITS'(MAX_TABLES);
      end else begin
         tab_active = ACT_BITS'(tiu_ff);
      end
   end
   assign tab_plus  = ACT_BITS'(tab_ff) + ACT_BITS'(1);
   assign slot_plus = slot_ff + FILL_BITS'(1);

   // Result register frees when empty or when its word is taken this cycle.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign dv_move    = dv_ff && rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Next state and outputs
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      hash_cnt_in = hash_cnt_ff;
      tab_in      = tab_ff;
      acc_in      = acc_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      bucket_in   = bucket_ff;
      is_add_in   = is_add_ff;
      id_in       = id_ff;
      btab_in     = btab_ff;

      fill_re     = 1'b0;
      fill_ra     = {tab_ff, acc_next};
      fill_we     = 1'b0;
      fill_wa     = bucket_ff;
      fill_wd     = '0;
      entry_re    = 1'b0;
      entry_ra    = {bucket_ff, slot_ff[SLOT_BITS-1:0]};
      entry_we    = 1'b0;
      entry_wa    = {bucket_ff, fill_rd_ff[SLOT_BITS-1:0]};
      empty_load  = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the fill memory to zero, one bucket a cycle.
            fill_we     = 1'b1;
            fill_wa     = clr_addr_ff;
            fill_wd     = '0;
            clr_addr_in = clr_addr_ff + BUCKET_BITS'(1);
            if (clr_addr_ff == BUCKET_BITS'(NUM_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     hash_cnt_in = '0;
                     tab_in      = '0;
                     acc_in      = '0;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_ADD, CMD_RETRIEVE: begin
                     if (index_done) begin
                        // Index complete: look up the bucket's fill count.
                        fill_re     = 1'b1;
                        bucket_in   = {tab_ff, acc_next};
                        is_add_in   = (cmd_type'(req_cmd) == CMD_ADD);
                        id_in       = req_item_id;
                        btab_in     = tab_ff;
                        hash_cnt_in = '0;
                        acc_in      = '0;
                        tab_in      = (tab_plus >= tab_active) ? '0
                                                               : tab_plus[TAB_BITS-1:0];
                        state_in    = ST_FILL;
                     end else begin
                        hash_cnt_in = hash_cnt_next;
                        acc_in      = acc_next;
                     end
                  end
                  default: ;   // unused command: drop the word
               endcase
            end
         end

         ST_FILL: begin
            if (is_add_ff) begin
               // Store the id at fill mod slots; saturate the count.
               entry_we = 1'b1;
               if (fill_rd_ff != FILL_BITS'(FILL_MAX)) begin
                  fill_we = 1'b1;
                  fill_wd = fill_rd_ff + FILL_BITS'(1);
               end
               state_in = ST_IDLE;
            end else if (fill_rd_ff == '0) begin
               state_in = ST_EMPTY;
            end else begin
               count_in = (fill_rd_ff >= FILL_BITS'(BUCKET_SLOTS))
                          ? FILL_BITS'(BUCKET_SLOTS) : fill_rd_ff;
               slot_in  = '0;
               state_in = ST_STREAM;
            end
         end

         ST_STREAM: begin
            // Issue a read only when the read data register will be free.
            if (!dv_ff || dv_move) begin
               entry_re = 1'b1;
               slot_in  = slot_plus;
               if (slot_plus == count_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_EMPTY: begin
            // Wait for earlier words to drain, then emit the empty marker.
            if (!dv_ff && rsp_free) begin
               empty_load = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Read data stage and result register. The read data carries its own table
   // number, since the next bucket may be taken before the last word drains.
   always_comb begin
      dv_in        = dv_ff;
      dv_last_in   = dv_last_ff;
      dv_tab_in    = dv_tab_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_tab_in   = rsp_tab_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;

      if (entry_re) begin
         dv_in      = 1'b1;
         dv_last_in = (slot_plus == count_ff);
         dv_tab_in  = btab_ff;
      end else if (dv_move) begin
         dv_in      = 1'b0;
      end

      if (dv_move) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = entry_rd_ff;
         rsp_tab_in   = tab_to_num(dv_tab_ff);
         rsp_empty_in = 1'b0;
         rsp_last_in  = dv_last_ff;
      end else if (empty_load) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         rsp_tab_in   = tab_to_num(btab_ff);
         rsp_empty_in = 1'b1;
         rsp_last_in  = 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         hash_cnt_ff  <= '0;
         tab_ff       <= '0;
         acc_ff       <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         dv_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         hash_cnt_ff  <= hash_cnt_in;
         tab_ff       <= tab_in;
         acc_ff       <= acc_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         dv_last_ff   <= dv_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff    <= bucket_in;
      is_add_ff    <= is_add_in;
      id_ff        <= id_in;
      btab_ff      <= btab_in;
      dv_tab_ff    <= dv_tab_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_tab_ff   <= rsp_tab_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_id       = rsp_id_ff;
   assign rsp_table_number   = rsp_tab_ff;
   assign rsp_bucket_empty   = rsp_empty_ff;
   assign rsp_last_of_bucket = rsp_last_ff;

endmodule
